FILE: design/lkec_pkg.sv
// ----------------------------------------------------------------------------
// LRU keyed entry cache package
// Shared types and constants for the keyed cache and its memories.
// ----------------------------------------------------------------------------
`default_nettype none
package lkec_pkg;
  localparam int unsigned Entries   = 16;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned IdxBits   = $clog2(Entries);
  localparam int unsigned CountBits = $clog2(Entries + 1);
  localparam int unsigned CapBits   = 5;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [KeyBits-1:0]  key;
    logic [DataBits-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [DataBits-1:0]  data_out;
    logic                 evicted;
    logic [KeyBits-1:0]   evicted_key;
    logic [CountBits-1:0] entry_count;
  } rsp_t;
endpackage
`default_nettype wire

FILE: design/lkec_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lkec_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/lru_keyed_entry_cache_unit.sv
// ----------------------------------------------------------------------------
// LRU keyed entry cache unit
// Fully associative key-to-data cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  req     | in        | req_valid_i, req_ready_o, req_i
//  rsp     | out       | rsp_valid_o, rsp_ready_i, rsp_o
//  cfg     | in        | cfg_we_i, cfg_data_i
// A command passes a scan, a done step and an update step: the scan reads one
// tag a cycle from the tag memory and compares it in the next cycle; the done
// step ends the last compare and reads data; the update step updates ranks.
// Valid bits and ranks sit in flip-flops and are cleared by reset at once.
// A new command is taken while the previous result still waits in rsp_o; the
// update cycle stalls until that result has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_keyed_entry_cache_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  output logic                             req_ready_o,
  input  wire lkec_pkg::req_t              req_i,
  output logic                             rsp_valid_o,
  input  wire logic                        rsp_ready_i,
  output lkec_pkg::rsp_t                   rsp_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [lkec_pkg::CapBits-1:0] cfg_data_i
);
  import lkec_pkg::*;

  state_e state_q, state_d;
  req_t req_q, req_d;
  logic [CapBits-1:0] cap_q;
  logic [Entries-1:0] valid_q, valid_d;
  logic [IdxBits-1:0] rank_q [Entries];
  logic [IdxBits-1:0] rank_d [Entries];
  logic [CountBits-1:0] occ_q, occ_d;
  logic [IdxBits:0] scan_q, scan_d;
  logic sv_q, sv_d;
  logic [IdxBits-1:0] sidx_q, sidx_d;
  logic found_q, found_d;
  logic [IdxBits-1:0] fidx_q, fidx_d;
  logic [IdxBits-1:0] oidx_q, oidx_d;
  logic ofound_q, ofound_d;
  logic [IdxBits-1:0] freeidx_q, freeidx_d;
  logic freefound_q, freefound_d;
  logic [KeyBits-1:0] okey_q, okey_d;
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  logic tag_we, data_we;
  logic [IdxBits-1:0] tag_wa, data_wa, tag_ra, data_ra;
  logic [KeyBits-1:0] tag_rd;
  logic [DataBits-1:0] data_rd;
  logic [CountBits-1:0] cap_eff;

  lkec_ram #(.Width(KeyBits), .Depth(Entries)) u_tag (
    .clk_i, .we_i(tag_we), .waddr_i(tag_wa), .wdata_i(req_q.key),
    .raddr_i(tag_ra), .rdata_o(tag_rd)
  );
  lkec_ram #(.Width(DataBits), .Depth(Entries)) u_data (
    .clk_i, .we_i(data_we), .waddr_i(data_wa), .wdata_i(req_q.data_in),
    .raddr_i(data_ra), .rdata_o(data_rd)
  );

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CountBits'(1);
    end else if (32'(cap_q) > Entries) begin
      cap_eff = CountBits'(Entries);
    end else begin
      cap_eff = CountBits'(cap_q);
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapBits'(16);
      valid_q     <= '0;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
      sv_q        <= 1'b0;
      for (int i = 0; i < Entries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
      sv_q        <= sv_d;
      rank_q      <= rank_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    scan_q      <= scan_d;
    sidx_q      <= sidx_d;
    found_q     <= found_d;
    fidx_q      <= fidx_d;
    oidx_q      <= oidx_d;
    ofound_q    <= ofound_d;
    freeidx_q   <= freeidx_d;
    freefound_q <= freefound_d;
    okey_q      <= okey_d;
    rsp_q       <= rsp_d;
  end

  always_comb begin
    logic [IdxBits-1:0] r;
    logic do_ins;
    logic [IdxBits-1:0] slot;
    state_d = state_q;
    req_d = req_q;
    valid_d = valid_q;
    rank_d = rank_q;
    occ_d = occ_q;
    scan_d = scan_q;
    sv_d = 1'b0;
    sidx_d = sidx_q;
    found_d = found_q;
    fidx_d = fidx_q;
    oidx_d = oidx_q;
    ofound_d = ofound_q;
    freeidx_d = freeidx_q;
    freefound_d = freefound_q;
    okey_d = okey_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    tag_we = 1'b0;
    data_we = 1'b0;
    tag_wa = '0;
    data_wa = '0;
    tag_ra = scan_q[IdxBits-1:0];
    data_ra = fidx_q;
    r = '0;
    do_ins = 1'b0;
    slot = '0;

    // Tag compare and oldest-rank check of the entry read in the previous cycle.
    if (sv_q && valid_q[sidx_q]) begin
      if (tag_rd == req_q.key && !found_d) begin
        found_d = 1'b1;
        fidx_d = sidx_q;
      end
      if (rank_q[sidx_q] == IdxBits'(occ_q - CountBits'(1))) begin
        ofound_d = 1'b1;
        oidx_d = sidx_q;
        okey_d = tag_rd;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          req_d = req_i;
          scan_d = '0;
          found_d = 1'b0;
          ofound_d = 1'b0;
          freefound_d = 1'b0;
          for (int i = Entries - 1; i >= 0; i--) begin
            if (!valid_q[i]) begin
              freefound_d = 1'b1;
              freeidx_d = IdxBits'(i);
            end
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        sv_d = 1'b1;
        sidx_d = scan_q[IdxBits-1:0];
        scan_d = scan_q + 1'b1;
        if (scan_q == (IdxBits+1)'(Entries - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        data_ra = fidx_d;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d = '0;
          rsp_d.hit = found_q && (req_q.cmd != CMD_CLEAR);
          if (req_q.cmd == CMD_CLEAR) begin
            valid_d = '0;
            for (int i = 0; i < Entries; i++) rank_d[i] = '0;
            occ_d = '0;
          end else if (found_q) begin
            r = rank_q[fidx_q];
            if (req_q.cmd == CMD_INVAL) begin
              valid_d[fidx_q] = 1'b0;
              for (int i = 0; i < Entries; i++) begin
                if (valid_q[i] && rank_q[i] > r) rank_d[i] = rank_q[i] - 1'b1;
              end
              occ_d = occ_q - 1'b1;
            end else begin
              if (req_q.cmd == CMD_LOOKUP) begin
                rsp_d.data_out = data_rd;
              end else begin
                data_we = 1'b1;
                data_wa = fidx_q;
              end
              for (int i = 0; i < Entries; i++) begin
                if (valid_q[i] && rank_q[i] < r) rank_d[i] = rank_q[i] + 1'b1;
              end
              rank_d[fidx_q] = '0;
            end
          end else if (req_q.cmd == CMD_STORE) begin
            do_ins = 1'b1;
            slot = freeidx_q;
            occ_d = occ_q;
            if (occ_q >= cap_eff && ofound_q) begin
              rsp_d.evicted = 1'b1;
              rsp_d.evicted_key = okey_q;
              slot = oidx_q;
              occ_d = occ_q - 1'b1;
            end else if (!freefound_q) begin
              do_ins = 1'b0;
            end
            if (do_ins) begin
              for (int i = 0; i < Entries; i++) begin
                if (valid_q[i] && IdxBits'(i) != slot) rank_d[i] = rank_q[i] + 1'b1;
              end
              rank_d[slot] = '0;
              valid_d[slot] = 1'b1;
              tag_we = 1'b1;
              tag_wa = slot;
              data_we = 1'b1;
              data_wa = slot;
              occ_d = occ_d + 1'b1;
            end
          end
          rsp_d.entry_count = occ_d;
          rsp_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CountBits'($countones(valid_q)))
    else $error("occupancy differs from valid count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !req_ready_o)
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |=> rsp_valid_q)
    else $error("result not posted");
endmodule
`default_nettype wire

FILE: verif/lkec_checker.sv
// ----------------------------------------------------------------------------
// LRU keyed entry cache checker
// Watches the command and result channels, keeps its own copy of the cache
// contents and recency order, predicts each result and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none
module lkec_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  input  wire logic                        req_ready_i,
  input  wire lkec_pkg::req_t              req_i,
  input  wire logic                        rsp_valid_i,
  input  wire logic                        rsp_ready_i,
  input  wire lkec_pkg::rsp_t              rsp_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [lkec_pkg::CapBits-1:0] cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               rsp_seen_o
);
  import lkec_pkg::*;

  logic [KeyBits-1:0]  tags   [Entries];
  logic [DataBits-1:0] datas  [Entries];
  logic                valids [Entries];
  int unsigned         ranks  [Entries];
  int unsigned         occupancy;
  logic [CapBits-1:0]  capacity;
  rsp_t                expected_rsps[$];

  function automatic int find_key(logic [KeyBits-1:0] key);
    for (int i = 0; i < Entries; i++) begin
      if (valids[i] && tags[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void make_recent(int s);
    int unsigned r;
    r = ranks[s];
    for (int i = 0; i < Entries; i++) begin
      if (valids[i] && ranks[i] < r) ranks[i]++;
    end
    ranks[s] = 0;
  endfunction

  function automatic void remove_slot(int s);
    int unsigned r;
    r = ranks[s];
    valids[s] = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (valids[i] && ranks[i] > r) ranks[i]--;
    end
    if (occupancy > 0) occupancy--;
  endfunction

  function automatic rsp_t predict_cache(req_t req);
    rsp_t        res;
    int          s;
    int          v;
    int unsigned cap;
    res = '0;
    cap = (capacity == 0) ? 1 : capacity;
    if (cap > Entries) cap = Entries;
    if (cmd_e'(req.cmd) == CMD_CLEAR) begin
      for (int i = 0; i < Entries; i++) begin
        valids[i] = 1'b0;
        ranks[i]  = 0;
      end
      occupancy = 0;
    end else begin
      s = find_key(req.key);
      res.hit = (s >= 0);
      if (cmd_e'(req.cmd) == CMD_LOOKUP) begin
        if (s >= 0) begin
          res.data_out = datas[s];
          make_recent(s);
        end
      end else if (cmd_e'(req.cmd) == CMD_INVAL) begin
        if (s >= 0) remove_slot(s);
      end else if (s >= 0) begin
        datas[s] = req.data_in;
        make_recent(s);
      end else begin
        if (occupancy >= cap) begin
          v = -1;
          for (int i = 0; i < Entries; i++) begin
            if (valids[i] && (v < 0 || ranks[i] > ranks[v])) v = i;
          end
          if (v >= 0) begin
            res.evicted     = 1'b1;
            res.evicted_key = tags[v];
            remove_slot(v);
          end
        end
        s = -1;
        for (int i = 0; i < Entries; i++) begin
          if (s < 0 && !valids[i]) s = i;
        end
        if (s >= 0) begin
          for (int i = 0; i < Entries; i++) begin
            if (valids[i]) ranks[i]++;
          end
          tags[s]   = req.key;
          datas[s]  = req.data_in;
          valids[s] = 1'b1;
          ranks[s]  = 0;
          occupancy++;
        end
      end
    end
    res.entry_count = occupancy[CountBits-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        valids[i] = 1'b0;
        ranks[i]  = 0;
        tags[i]   = '0;
        datas[i]  = '0;
      end
      occupancy = 0;
      capacity  = 5'd16;
      expected_rsps.delete();
      fail_count_o = 0;
      rsp_seen_o   = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        rsp_seen_o++;
        if (expected_rsps.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("ERROR: unexpected result %h", rsp_i);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_i.hit !== exp_rsp.hit || rsp_i.data_out !== exp_rsp.data_out ||
              rsp_i.evicted !== exp_rsp.evicted ||
              rsp_i.evicted_key !== exp_rsp.evicted_key ||
              rsp_i.entry_count !== exp_rsp.entry_count) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("ERROR: result mismatch hit %b/%b data %h/%h ev %b/%b evkey %h/%h cnt %0d/%0d",
                       exp_rsp.hit, rsp_i.hit, exp_rsp.data_out, rsp_i.data_out,
                       exp_rsp.evicted, rsp_i.evicted, exp_rsp.evicted_key,
                       rsp_i.evicted_key, exp_rsp.entry_count, rsp_i.entry_count);
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_rsps.push_back(predict_cache(req_i));
      if (cfg_we_i) capacity = cfg_data_i;
    end
    pending_o = expected_rsps.size();
  end
endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// LRU keyed entry cache testbench
// Drives directed and random cache commands at several capacities and
// idling phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import lkec_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               req_valid_i = 1'b0;
  logic               req_ready_o;
  req_t               req_i = '0;
  logic               rsp_valid_o;
  logic               rsp_ready_i = 1'b0;
  rsp_t               rsp_o;
  logic               cfg_we_i = 1'b0;
  logic [CapBits-1:0] cfg_data_i = '0;
  int                 fail_count;
  int                 pending;
  int                 rsp_seen;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_off_cycles = 0;
  int                 item_count = 0;
  logic [KeyBits-1:0] key_pool[8];

  always #5 clk_i = ~clk_i;

  lru_keyed_entry_cache_unit dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o, .cfg_we_i, .cfg_data_i
  );

  lkec_checker u_checker (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_i(req_ready_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_ready_i, .rsp_i(rsp_o), .cfg_we_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .rsp_seen_o(rsp_seen)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("lru_keyed_entry_cache_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [KeyBits-1:0] key, logic [DataBits-1:0] din);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= '{cmd: cmd, key: key, data_in: din};
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    item_count++;
  endtask

  task automatic drain_results();
    req_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Entries + 8) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CapBits-1:0] cap);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int                  sel;
    logic [1:0]          cmd;
    logic [KeyBits-1:0]  key;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) cmd = CMD_STORE;
      else if (sel < 80) cmd = CMD_LOOKUP;
      else if (sel < 97) cmd = CMD_INVAL;
      else cmd = CMD_CLEAR;
      key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
      send_item(cmd, key, $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_LOOKUP, 32'h0, 32'h0);
    send_item(CMD_STORE, 32'h0, 32'hFFFF_FFFF);
    send_item(CMD_STORE, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_LOOKUP, 32'h0, 32'h0);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h1234);
    send_item(CMD_STORE, 32'h0, 32'hA5A5_5A5A);
    send_item(CMD_INVAL, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_INVAL, 32'h1357, 32'h0);
    for (int i = 0; i < 17; i++) send_item(CMD_STORE, 32'h100 + i, $urandom());
    send_item(CMD_CLEAR, 32'h100, 32'h0);
    send_item(CMD_LOOKUP, 32'h101, 32'h0);

    set_capacity(5'd0);
    send_item(CMD_STORE, 32'h5, 32'h55);
    send_item(CMD_STORE, 32'h6, 32'h66);
    set_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_item(CMD_STORE, $urandom(), $urandom());
    set_capacity(5'd3);
    send_item(CMD_STORE, 32'h77, 32'h7);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      set_capacity(($urandom_range(1) != 0) ? 5'($urandom_range(6)) : 5'($urandom_range(31)));
      random_phase(60);
      drain_results();
      set_capacity(5'd16);
      if (ph == 1) begin
        hold_off_cycles = 300;
        random_phase(10);
      end
      random_phase(40);
    end

    drain_results();
    $display("Ran %0d commands over capacities 0, 1-6, 16 and 31 with four idling phases.",
             item_count);
    $display("Checked %0d results, %0d failures.", rsp_seen, fail_count);
    if (fail_count == 0) begin
      $display("lru_keyed_entry_cache_unit verification clean");
    end else begin
      $display("lru_keyed_entry_cache_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
